[sv/hpsi_pkg.sv]
// hpsi_pkg: shared constants, register codes and small arithmetic tables
// for the Halton pixel-to-sample-index pipeline. No dependencies.

package hpsi_pkg;

    localparam int unsigned COORD_W  = 16;
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned INDEX_W  = 47;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 8;

    // pipeline depth in register stages
    localparam int unsigned NSTG = 9;

    // Coordinates wrap at the maximum resolution (a power of two).
    localparam int unsigned RES_W   = 7;
    localparam int unsigned DIG3_N  = 5;   // base-3 digits of a wrapped coordinate
    localparam int unsigned YS_W    = 8;   // 3^5 = 243
    localparam int unsigned STRIDE_W = 15; // 243 * 128 = 31104
    localparam int unsigned PY_W    = 16;
    localparam int unsigned RECIP_W = 25;
    localparam int unsigned RECIP_SH = 24;

    localparam logic [2:0] Y_DIGITS_MAX = 3'd5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_X_DIGITS  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_Y_DIGITS  = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_X_INVERSE = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_Y_INVERSE = t_cfg_idx'(3);

    typedef logic [DIG3_N-1:0][1:0] t_dig3;

    // 3^n for n = 0..5
    function automatic logic [YS_W-1:0] pow3(input logic [2:0] n);
        logic [YS_W-1:0] r;
        unique case (n)
            3'd0:    r = 8'd1;
            3'd1:    r = 8'd3;
            3'd2:    r = 8'd9;
            3'd3:    r = 8'd27;
            3'd4:    r = 8'd81;
            default: r = 8'd243;
        endcase
        return r;
    endfunction

    // ceil(2^24 / 3^n): floor(v * M >> 24) is exact for v < 2^16
    function automatic logic [RECIP_W-1:0] recip3(input logic [2:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            3'd0:    r = 25'd16777216;
            3'd1:    r = 25'd5592406;
            3'd2:    r = 25'd1864136;
            3'd3:    r = 25'd621379;
            3'd4:    r = 25'd207127;
            default: r = 25'd69043;
        endcase
        return r;
    endfunction

    // Base-3 digits, least significant first; v/3 as (v * 171) >> 9, exact below 512
    function automatic t_dig3 base3_digits(input logic [RES_W-1:0] w);
        logic [7:0]  v;
        logic [16:0] t;
        logic [7:0]  q;
        t_dig3       d;
        v = {1'b0, w};
        for (int i = 0; i < DIG3_N; i++) begin
            t    = 17'(v) * 17'd171;
            q    = t[16:9];
            d[i] = 2'(v - 8'((q << 1) + q));
            v    = q;
        end
        return d;
    endfunction

endpackage

[sv/halton_pixel_sample_index_top.sv]
// Halton pixel-to-sample-index top level: nine-stage pipeline with
// per-stage valid bits and a ripple stall chain. Depends on hpsi_pkg.
// Throughput: one item per cycle while the output is ready; bubbles collapse while it stalls.
// Reset (synchronous, active low) empties the pipeline and loads the
// configuration defaults: x_digits 7, y_digits 5, x_inverse 59, y_inverse 131.

module halton_pixel_sample_index_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  hpsi_pkg::t_cfg_idx                    i_cfg_idx,
    input  logic [hpsi_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [hpsi_pkg::COORD_W-1:0]   i_pixel_x,
    input  logic signed [hpsi_pkg::COORD_W-1:0]   i_pixel_y,
    input  logic [hpsi_pkg::SAMPLE_W-1:0]         i_sample_number,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [hpsi_pkg::INDEX_W-1:0]          o_global_index
);

    // configuration
    logic [2:0] r_x_digits;
    logic [2:0] r_y_digits;
    logic [6:0] r_x_inverse;
    logic [7:0] r_y_inverse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_digits  <= 3'd7;
            r_y_digits  <= 3'd5;
            r_x_inverse <= 7'd59;
            r_y_inverse <= 8'd131;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hpsi_pkg::CFG_X_DIGITS:  r_x_digits  <= i_cfg_data[2:0];
                hpsi_pkg::CFG_Y_DIGITS:  r_y_digits  <= i_cfg_data[2:0];
                hpsi_pkg::CFG_X_INVERSE: r_x_inverse <= i_cfg_data[6:0];
                hpsi_pkg::CFG_Y_INVERSE: r_y_inverse <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [2:0]                          yd;
    logic [hpsi_pkg::YS_W-1:0]           ys;
    logic [hpsi_pkg::RES_W-1:0]          xmask;
    logic [hpsi_pkg::STRIDE_W-1:0]       stride;
    logic [hpsi_pkg::RECIP_W-1:0]        recip;

    always_comb begin
        yd     = (r_y_digits > hpsi_pkg::Y_DIGITS_MAX) ? hpsi_pkg::Y_DIGITS_MAX : r_y_digits;
        ys     = hpsi_pkg::pow3(yd);
        recip  = hpsi_pkg::recip3(yd);
        xmask  = 7'((8'd1 << r_x_digits) - 8'd1);
        stride = hpsi_pkg::STRIDE_W'(ys) << r_x_digits;
    end

    // stall chain: a stage loads when it is empty or its content moves on
    logic [hpsi_pkg::NSTG:1] r_vld;
    logic [hpsi_pkg::NSTG:1] en;

    always_comb begin
        en[hpsi_pkg::NSTG] = !r_vld[hpsi_pkg::NSTG] || i_ready;
        for (int k = hpsi_pkg::NSTG - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= i_valid;
            for (int k = 2; k <= hpsi_pkg::NSTG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_ready = en[1];
    assign o_valid = r_vld[hpsi_pkg::NSTG];

    // stage 1: wrap coordinates, bit-reverse x, split y into base-3 digits
    logic [hpsi_pkg::RES_W-1:0]    n1_rev;
    logic [hpsi_pkg::RES_W-1:0]    n1_dx;
    logic [hpsi_pkg::RES_W-1:0]    r1_dx;
    hpsi_pkg::t_dig3               r1_dig;
    logic [hpsi_pkg::SAMPLE_W-1:0] r1_sample;

    always_comb begin
        for (int j = 0; j < hpsi_pkg::RES_W; j++) begin
            n1_rev[j] = i_pixel_x[hpsi_pkg::RES_W-1-j];
        end
        n1_dx = n1_rev >> (3'd7 - r_x_digits);
    end

    // stage 2: assemble reversed y, x term of the CRT, sample times stride
    logic [hpsi_pkg::YS_W-1:0]     n2_dy;
    logic [13:0]                   n2_axp;
    logic [hpsi_pkg::YS_W-1:0]     r2_dy;
    logic [hpsi_pkg::RES_W-1:0]    r2_ax;
    logic [hpsi_pkg::INDEX_W-1:0]  r2_prod;

    always_comb begin
        n2_dy = '0;
        for (int i = 0; i < hpsi_pkg::DIG3_N; i++) begin
            if (3'(i) < yd) begin
                n2_dy = 8'((n2_dy << 1) + n2_dy + {6'd0, r1_dig[i]});
            end
        end
        n2_axp = 14'(r1_dx) * 14'(r_x_inverse);
    end

    // stage 3: y term product
    logic [hpsi_pkg::PY_W-1:0]     r3_py;
    logic [hpsi_pkg::RES_W-1:0]    r3_ax;
    logic [hpsi_pkg::INDEX_W-1:0]  r3_prod;

    // stage 4: quotient by 3^yd through the reciprocal
    logic [40:0]                   n4_t;
    logic [hpsi_pkg::PY_W-1:0]     r4_q;
    logic [hpsi_pkg::PY_W-1:0]     r4_py;
    logic [hpsi_pkg::RES_W-1:0]    r4_ax;
    logic [hpsi_pkg::INDEX_W-1:0]  r4_prod;

    assign n4_t = 41'(r3_py) * 41'(recip);

    // stage 5: remainder by 3^yd
    logic [23:0]                   n5_qd;
    logic [hpsi_pkg::YS_W-1:0]     r5_rb;
    logic [hpsi_pkg::RES_W-1:0]    r5_ax;
    logic [hpsi_pkg::INDEX_W-1:0]  r5_prod;

    always_comb begin
        n5_qd = 24'(r4_q) * 24'(ys);
    end

    // stage 6: scale both residues back onto the stride
    logic [hpsi_pkg::STRIDE_W-1:0] r6_a;
    logic [hpsi_pkg::STRIDE_W-1:0] r6_b;
    logic [hpsi_pkg::INDEX_W-1:0]  r6_prod;

    // stage 7: sum of the two terms, below twice the stride
    logic [hpsi_pkg::STRIDE_W:0]   r7_sum;
    logic [hpsi_pkg::INDEX_W-1:0]  r7_prod;

    // stage 8: fold into the stride
    logic [hpsi_pkg::STRIDE_W-1:0] r8_off;
    logic [hpsi_pkg::INDEX_W-1:0]  r8_prod;

    // stage 9: result register
    logic [hpsi_pkg::INDEX_W-1:0]  r9_index;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_dx     <= n1_dx;
            r1_dig    <= hpsi_pkg::base3_digits(i_pixel_y[hpsi_pkg::RES_W-1:0]);
            r1_sample <= i_sample_number;
        end
        if (en[2]) begin
            r2_dy   <= n2_dy;
            r2_ax   <= n2_axp[hpsi_pkg::RES_W-1:0] & xmask;
            r2_prod <= hpsi_pkg::INDEX_W'(r1_sample) * hpsi_pkg::INDEX_W'(stride);
        end
        if (en[3]) begin
            r3_py   <= 16'(r2_dy) * 16'(r_y_inverse);
            r3_ax   <= r2_ax;
            r3_prod <= r2_prod;
        end
        if (en[4]) begin
            r4_q    <= n4_t[hpsi_pkg::RECIP_SH +: hpsi_pkg::PY_W];
            r4_py   <= r3_py;
            r4_ax   <= r3_ax;
            r4_prod <= r3_prod;
        end
        if (en[5]) begin
            r5_rb   <= 8'(r4_py - n5_qd[hpsi_pkg::PY_W-1:0]);
            r5_ax   <= r4_ax;
            r5_prod <= r4_prod;
        end
        if (en[6]) begin
            r6_a    <= hpsi_pkg::STRIDE_W'(ys) * hpsi_pkg::STRIDE_W'(r5_ax);
            r6_b    <= hpsi_pkg::STRIDE_W'(r5_rb) << r_x_digits;
            r6_prod <= r5_prod;
        end
        if (en[7]) begin
            r7_sum  <= {1'b0, r6_a} + {1'b0, r6_b};
            r7_prod <= r6_prod;
        end
        if (en[8]) begin
            r8_off  <= (r7_sum >= {1'b0, stride})
                       ? hpsi_pkg::STRIDE_W'(r7_sum - {1'b0, stride})
                       : r7_sum[hpsi_pkg::STRIDE_W-1:0];
            r8_prod <= r7_prod;
        end
        if (en[9]) begin
            r9_index <= r8_prod + hpsi_pkg::INDEX_W'(r8_off);
        end
    end

    assign o_global_index = r9_index;

endmodule

[sv/hpsi_checker.sv]
// hpsi_checker: port-level assertions for halton_pixel_sample_index_top,
// attached by the bind at the end of this file. Depends on hpsi_pkg.

module hpsi_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_ready,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic [hpsi_pkg::INDEX_W-1:0]          o_global_index
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_global_index))
        else $error("result changed or dropped while stalled");

    // an empty output stage never blocks the input
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with no result pending");

    // a result leaving frees room for a new transfer
    a_ready_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |-> o_ready)
        else $error("input stalled while the output drains");

endmodule

bind halton_pixel_sample_index_top hpsi_checker u_hpsi_checker (.*);

[dv/hpsi_index_checker.sv]
`timescale 1ns / 1ps
// hpsi_index_checker: watches the configuration port and both transfer channels of the
// Halton pixel-to-sample-index block, predicts each global index and compares in order.
// Depends on hpsi_pkg for register codes and widths.

module hpsi_index_checker
    import hpsi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  t_cfg_idx                i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic signed [COORD_W-1:0] i_pixel_x,
    input  logic signed [COORD_W-1:0] i_pixel_y,
    input  logic [SAMPLE_W-1:0]     i_sample_number,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [INDEX_W-1:0]      i_global_index,
    output int unsigned             o_errors,
    output int unsigned             o_pending,
    output int unsigned             o_checked
);

    localparam logic [2:0] RESET_X_DIGITS  = 3'd7;
    localparam logic [2:0] RESET_Y_DIGITS  = 3'd5;
    localparam logic [6:0] RESET_X_INVERSE = 7'd59;
    localparam logic [7:0] RESET_Y_INVERSE = 8'd131;

    logic [2:0] cfg_x_digits  = RESET_X_DIGITS;
    logic [2:0] cfg_y_digits  = RESET_Y_DIGITS;
    logic [6:0] cfg_x_inverse = RESET_X_INVERSE;
    logic [7:0] cfg_y_inverse = RESET_Y_INVERSE;

    logic [INDEX_W-1:0] expected_index_q[$];
    int unsigned n_errors  = 0;
    int unsigned n_checked = 0;

    function automatic logic [INDEX_W-1:0] predict_global_index(
        logic signed [COORD_W-1:0] px,
        logic signed [COORD_W-1:0] py,
        logic [SAMPLE_W-1:0]       sn
    );
        int unsigned       yd, xs, ys, stride, wx, wy, dx, dy, k;
        longint unsigned   offset;
        yd = (cfg_y_digits > Y_DIGITS_MAX) ? Y_DIGITS_MAX : cfg_y_digits;
        xs = 1 << cfg_x_digits;
        ys = 1;
        for (k = 0; k < yd; k++) ys = ys * 3;
        stride = xs * ys;
        offset = 0;
        if (stride > 1) begin
            // the resolution is a power of two, so the low bits are the non-negative residue
            wx = px[RES_W-1:0];
            wy = py[RES_W-1:0];
            dx = 0;
            dy = 0;
            for (k = 0; k < cfg_x_digits; k++) begin
                dx = dx * 2 + wx % 2;
                wx = wx / 2;
            end
            for (k = 0; k < yd; k++) begin
                dy = dy * 3 + wy % 3;
                wy = wy / 3;
            end
            offset = (longint'(dx) * ys * cfg_x_inverse + longint'(dy) * xs * cfg_y_inverse)
                     % stride;
        end
        return INDEX_W'(offset + longint'(sn) * stride);
    endfunction

    always @(posedge i_clk) begin
        logic [INDEX_W-1:0] want;
        if (!i_rst_n) begin
            cfg_x_digits  = RESET_X_DIGITS;
            cfg_y_digits  = RESET_Y_DIGITS;
            cfg_x_inverse = RESET_X_INVERSE;
            cfg_y_inverse = RESET_Y_INVERSE;
            expected_index_q.delete();
        end else begin
            // retire before predicting: a result never leaves in the cycle its input enters
            if (i_out_valid && i_out_ready) begin
                if (expected_index_q.size() == 0) begin
                    $error("global_index: no result expected, actual %0d", i_global_index);
                    n_errors++;
                end else begin
                    want = expected_index_q.pop_front();
                    n_checked++;
                    if (i_global_index !== want) begin
                        $error("global_index: expected %0d, actual %0d", want, i_global_index);
                        n_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_index_q.push_back(
                    predict_global_index(i_pixel_x, i_pixel_y, i_sample_number));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_X_DIGITS:  cfg_x_digits  = i_cfg_data[2:0];
                    CFG_Y_DIGITS:  cfg_y_digits  = i_cfg_data[2:0];
                    CFG_X_INVERSE: cfg_x_inverse = i_cfg_data[6:0];
                    CFG_Y_INVERSE: cfg_y_inverse = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_index_q.size();
        o_errors  <= n_errors;
        o_checked <= n_checked;
    end

endmodule

[dv/tb_halton_pixel_sample_index_top.sv]
`timescale 1ns / 1ps
// tb_halton_pixel_sample_index_top: stimulus and verdict for the Halton pixel-to-sample-index
// block across many register settings and idle patterns. Depends on hpsi_pkg, the block
// and hpsi_index_checker.

module tb_halton_pixel_sample_index_top;

    import hpsi_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 300000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_ITEMS  = 102;
    localparam int unsigned NUM_PHASES   = 12;
    localparam int unsigned DRAIN_CYCLES = 14;
    localparam int unsigned PRESSURE_PHASE = 4;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_cfg_we        = 1'b0;
    t_cfg_idx                  i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data      = '0;
    logic                      i_valid         = 1'b0;
    logic                      o_ready;
    logic signed [COORD_W-1:0] i_pixel_x       = '0;
    logic signed [COORD_W-1:0] i_pixel_y       = '0;
    logic [SAMPLE_W-1:0]       i_sample_number = '0;
    logic                      o_valid;
    logic                      i_ready         = 1'b0;
    logic [INDEX_W-1:0]        o_global_index;

    int unsigned errors, pending, checked;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    logic        hold_go      = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned cycle_count  = 0;
    int unsigned n_items      = 0;
    int unsigned n_settings   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    halton_pixel_sample_index_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_sample_number (i_sample_number),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_global_index  (o_global_index)
    );

    hpsi_index_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_sample_number (i_sample_number),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_global_index  (o_global_index),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // Result side: random stalls, or a long counted hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_go)
            hold_left = HOLD_CYCLES;
        if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned mod_inverse(int unsigned a, int unsigned m);
        int unsigned k;
        for (k = 0; k < m; k++)
            if ((a * k) % m == 1 % m)
                return k;
        return 0;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        logic [COORD_W-1:0] c;
        case ($urandom_range(3))
            0:       c = COORD_W'($urandom);
            3:       c = COORD_W'(($urandom_range(511) - 256) * 128 + $urandom_range(2) - 1);
            default: c = COORD_W'($urandom_range(600) - 300);
        endcase
        return c;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Unused upper bits carry noise; one write goes past the register map.
    task automatic apply_setting(int unsigned xd, int unsigned yd,
                                 int unsigned xinv, int unsigned yinv);
        write_reg(t_cfg_idx'($urandom_range(15, 4)), CFG_DATA_W'($urandom));
        write_reg(CFG_X_DIGITS,  {5'($urandom), 3'(xd)});
        write_reg(CFG_Y_DIGITS,  {5'($urandom), 3'(yd)});
        write_reg(CFG_X_INVERSE, {1'($urandom), 7'(xinv)});
        write_reg(CFG_Y_INVERSE, 8'(yinv));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_item(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                             logic [SAMPLE_W-1:0] sn);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_pixel_x       <= px;
        i_pixel_y       <= py;
        i_sample_number <= sn;
        do @(posedge i_clk); while (!o_ready);
        n_items++;
    endtask

    task automatic random_item();
        logic [SAMPLE_W-1:0] sn;
        case ($urandom_range(7))
            0:       sn = '1;
            1, 2:    sn = SAMPLE_W'($urandom_range(15));
            default: sn = SAMPLE_W'($urandom);
        endcase
        send_item(rand_coord(), rand_coord(), sn);
    endtask

    // Let the last accepted transfer reach the checker before looking at the count.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [COORD_W-1:0]  corner [12];
        logic [SAMPLE_W-1:0] sn_corner [4];
        int unsigned xd, yd, yd_eff, xs, ys, xinv, yinv, p, i;
        bit          use_inverses;

        corner = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h007F, 16'h0080,
                   16'hFF80, 16'hFF7F, 16'h0001, 16'h0040, 16'h003F, 16'h5555};
        sn_corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Coordinate and sample extremes under the reset register values.
        for (i = 0; i < 24; i++)
            send_item(corner[i % 12], corner[(i * 5 + 3) % 12], sn_corner[i % 4]);
        drain();

        for (p = 0; p < NUM_PHASES; p++) begin
            use_inverses = 1'b1;
            xinv = $urandom_range(127);
            yinv = $urandom_range(255);
            case (p)
                0: begin xd = 0; yd = 0; use_inverses = 1'b0; end  // unit stride
                1: begin xd = 7; yd = 5; end
                2: begin xd = 0; yd = 5; end
                3: begin xd = 7; yd = 0; end
                4: begin xd = 3; yd = 6; end                        // saturates to five digits
                5: begin xd = 5; yd = 7; end
                6: begin xd = 7; yd = 5; xinv = 127; yinv = 255; use_inverses = 1'b0; end
                7: begin xd = 7; yd = 5; xinv = 0;   yinv = 0;   use_inverses = 1'b0; end
                default: begin
                    xd = $urandom_range(7);
                    yd = $urandom_range(7);
                    use_inverses = (p != 10);
                end
            endcase
            if (use_inverses) begin
                yd_eff = (yd > 5) ? 5 : yd;
                xs = 1 << xd;
                ys = 1;
                repeat (yd_eff) ys = ys * 3;
                xinv = mod_inverse(ys % xs, xs);
                yinv = mod_inverse(xs % ys, ys);
            end
            apply_setting(xd, yd, xinv, yinv);

            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 46; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 46; end
                default: begin tx_idle_pct = 24; rx_stall_pct <= 24; end
            endcase

            // Hold the result side off while items keep coming, so the input backs up.
            if (p == PRESSURE_PHASE) begin
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end

            repeat (PHASE_ITEMS) random_item();
            drain();
        end

        $display("Covered %0d items over %0d register settings plus reset values; %0d results compared.",
                 n_items, n_settings, checked);
        $display("Included unit stride, saturated base-3 digits, bad inverses and a long output hold.");
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
sv/hpsi_pkg.sv
sv/halton_pixel_sample_index_top.sv
sv/hpsi_checker.sv
dv/hpsi_index_checker.sv
dv/tb_halton_pixel_sample_index_top.sv
